// ===== rtl/wfba_pkg.sv =====
// Package for the worst-fit block allocator.
// Holds the sizes, action and result codes, and the controller/datapath
// command and status types. No dependencies.
`default_nettype none

package wfba_pkg;

  // Storage sizing.
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 24;

  // Fixed field widths of the words on the channels.
  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 4;
  localparam int SPACE_W  = 24;
  localparam int CODE_W   = 2;
  localparam int COUNT_W  = 5;

  // Derived widths: table address and a counter that can hold NUM_BLOCKS.
  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CODE_W-1:0]   code_t;

  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_ALLOC = 2'd1;
  localparam action_t ACT_READ  = 2'd2;
  localparam action_t ACT_NONE  = 2'd3;

  localparam code_t RC_LOADED  = 2'd0;
  localparam code_t RC_ALLOC   = 2'd1;
  localparam code_t RC_NOALLOC = 2'd2;
  localparam code_t RC_READ    = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the incoming word
    logic scan_start;  // clear the scan counter and the best candidate
    logic scan;        // advance the scan by one entry
    logic load_wr;     // write the table and post a load result
    logic alloc_wr;    // update the chosen block and post an allocate result
    logic post_read;   // post a read result from the read register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;   // every entry in use has been compared
    logic out_free;    // the output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/wfba_if.sv =====
// Channel interfaces of the worst-fit block allocator: request and response.
// Depends on wfba_pkg for the field widths.
`default_nettype none

interface wfba_req_if import wfba_pkg::*;
  ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [BLOCK_W-1:0]  block_index;
  logic [23:0]         size_value;

  modport source (output valid, action, block_index, size_value, input ready);
  modport sink   (input valid, action, block_index, size_value, output ready);
endinterface

interface wfba_rsp_if import wfba_pkg::*;
  ();
  logic               valid;
  logic               ready;
  code_t              result_code;
  logic [BLOCK_W-1:0] block_number;
  logic [SPACE_W-1:0] space_left;

  modport source (output valid, result_code, block_number, space_left, input ready);
  modport sink   (input valid, result_code, block_number, space_left, output ready);
endinterface

`default_nettype wire

// ===== rtl/worst_fit_block_allocator.sv =====
// Worst-fit block allocator, top level. A load passes S_LOAD, a read S_READ and S_RDRES,
// and an allocate S_SCAN and S_ALLOC, where the scan covers the first used entries and used
// is block_count capped at NUM_BLOCKS; the scan reads one entry a cycle.
// One word is in work at a time; action 3 is accepted and needs no work. A stalled receiver
// holds the next word at its result step. Reset (rst, synchronous) clears block_count,
// the controller and the output register; the table holds nothing until loaded.
`default_nettype none

module worst_fit_block_allocator import wfba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  wfba_req_if.sink           req,
  wfba_rsp_if.source         rsp
);

  // The controller sequences each request word: a load writes the table in
  // one step, a read waits in S_READ for the registered table data, and an
  // allocate walks the first used entries, keeping the largest fitting block
  // with the lowest index on ties, then writes back the reduced size.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  wfba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath owns the output register, so the next request word can be
  // accepted while a finished result word still waits on the response side.
  wfba_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_action      (req.action),
    .in_block_index (req.block_index),
    .in_size_value  (req.size_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_code       (rsp.result_code),
    .out_block      (rsp.block_number),
    .out_space      (rsp.space_left)
  );

  // A result is only posted when the output register can take it.
  a_post_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_wr || cmd.alloc_wr || cmd.post_read) |-> stat.out_free)
    else $error("result posted while the output register was occupied");

  // At most one table-writing or result-posting step per cycle.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_wr, cmd.alloc_wr, cmd.post_read}))
    else $error("more than one result step in one cycle");

  // A request word that needs work keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.action != ACT_NONE) |=> !req.ready)
    else $error("request accepted while the previous one is in work");

  // A failed allocation reports block zero with no space.
  a_noalloc_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_code == RC_NOALLOC) |->
      (rsp.block_number == '0 && rsp.space_left == '0))
    else $error("not-allocated result carries a block or space");

endmodule

`default_nettype wire

// ===== rtl/wfba_ctrl.sv =====
// Controller state machine of the worst-fit block allocator.
// Depends on wfba_pkg; drives the datapath through dp_cmd_t only.
`default_nettype none

module wfba_ctrl import wfba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  action_t  req_action,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RDRES = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_ALLOC = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          unique case (req_action)
            ACT_LOAD:  state_next = S_LOAD;
            ACT_ALLOC: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            ACT_READ:  state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_wr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      // The table read of the addressed block is issued here.
      S_READ: state_next = S_RDRES;
      S_RDRES: begin
        if (stat.out_free) begin
          cmd.post_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat.out_free) begin
          cmd.alloc_wr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/wfba_dp.sv =====
// Datapath of the worst-fit block allocator: free-space table, scan
// comparator, block count register and output register. Depends on wfba_pkg.
`default_nettype none

module wfba_dp import wfba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  input  action_t            in_action,
  input  logic [BLOCK_W-1:0] in_block_index,
  input  logic [23:0]        in_size_value,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_ready,
  output code_t              out_code,
  output logic [BLOCK_W-1:0] out_block,
  output logic [SPACE_W-1:0] out_space
);

  logic [COUNT_W-1:0]   block_count;
  logic [BLOCK_W-1:0]   req_idx;
  logic [SIZE_BITS-1:0] req_size;

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     waddr;
  logic [SIZE_BITS-1:0] wdata;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     used;
  logic                 cmp_pend;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [SIZE_BITS-1:0] best_val;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] alloc_left;

  logic                 idx_in_range;
  logic [IDX_W-1:0]     idx_addr;
  logic                 post;
  code_t                res_code;
  logic [BLOCK_W-1:0]   res_block;
  logic [SPACE_W-1:0]   res_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
    end else if (cfg_we) begin
      block_count <= cfg_data;
    end
  end

  // The action itself is decoded by the controller.
  always_ff @(posedge clk) begin
    if (cmd.capture && in_action != ACT_NONE) begin
      req_idx  <= in_block_index;
      req_size <= SIZE_BITS'(in_size_value);
    end
  end

  assign idx_in_range = 32'(req_idx) < NUM_BLOCKS;
  assign idx_addr     = IDX_W'(req_idx);

  always_comb begin
    if (32'(block_count) >= NUM_BLOCKS) begin
      used = CNT_W'(NUM_BLOCKS);
    end else begin
      used = CNT_W'(block_count);
    end
  end

  assign alloc_left = best_val - req_size;
  assign raddr      = cmd.scan ? cnt[IDX_W-1:0] : idx_addr;
  assign mem_we     = (cmd.load_wr && idx_in_range) || (cmd.alloc_wr && found);
  assign waddr      = cmd.load_wr ? idx_addr : best_idx;
  assign wdata      = cmd.load_wr ? req_size : alloc_left;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // One entry is read per cycle and compared in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      cmp_pend <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan_start) begin
      cnt      <= '0;
      cmp_pend <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      if (cnt < used) begin
        cnt      <= cnt + CNT_W'(1);
        cmp_pend <= 1'b1;
        cmp_idx  <= cnt[IDX_W-1:0];
      end else begin
        cmp_pend <= 1'b0;
      end
      if (cmp_pend && rd_data >= req_size && (!found || rd_data > best_val)) begin
        found    <= 1'b1;
        best_val <= rd_data;
        best_idx <= cmp_idx;
      end
    end
  end

  assign stat.scan_done = (cnt == used) && !cmp_pend;
  assign stat.out_free  = !out_valid || out_ready;

  assign post = cmd.load_wr || cmd.alloc_wr || cmd.post_read;

  always_comb begin
    priority if (cmd.load_wr) begin
      res_code  = RC_LOADED;
      res_block = req_idx;
      res_space = idx_in_range ? SPACE_W'(req_size) : '0;
    end else if (cmd.alloc_wr) begin
      res_code  = found ? RC_ALLOC : RC_NOALLOC;
      res_block = found ? BLOCK_W'(best_idx) : '0;
      res_space = found ? SPACE_W'(alloc_left) : '0;
    end else begin
      res_code  = RC_READ;
      res_block = req_idx;
      res_space = idx_in_range ? SPACE_W'(rd_data) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      out_code  <= res_code;
      out_block <= res_block;
      out_space <= res_space;
    end
  end

endmodule

`default_nettype wire
